@@ design/acs_pkg.sv @@
// Shared types, constants and helper functions of the ADC smoothing and glitch check block.
package acs_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [8:0]  WARM_SCANS    = 9'd300;
    localparam logic [8:0]  WARM_FALLBACK = 9'd10;
    localparam logic [8:0]  WARM_REENTRY  = WARM_SCANS - WARM_FALLBACK;
    localparam int          SMOOTH_DIV    = 3;
    localparam int          DIV3_SHIFT    = 17;
    localparam logic [16:0] DIV3_RECIP    = 17'(((1 << DIV3_SHIFT) + 1) / SMOOTH_DIV);

    localparam logic [15:0] TOLERANCE_RESET = 16'd1000;
    localparam logic [3:0]  ACTIVE_RESET    = 4'd8;
    localparam logic [3:0]  CHECKED_RESET   = 4'd3;

    typedef enum logic [1:0] {
        CFG_TOLERANCE = 2'd0,
        CFG_ACTIVE    = 2'd1,
        CFG_CHECKED   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] tolerance;
        logic [3:0]  active_channels;
        logic [3:0]  checked_channels;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  channel;
        logic [15:0] sample;
        logic        last_in_scan;
    } item_t;

    typedef struct packed {
        logic [15:0] average;
        logic        glitch;
        logic        update;
    } calc_t;

    // Truncating divide of a 16-bit value by three through a reciprocal multiply.
    function automatic logic [15:0] div3(input logic [15:0] x);
        logic [32:0] prod;
        prod = {17'd0, x} * {16'd0, DIV3_RECIP};
        return prod[32:17];
    endfunction

endpackage

@@ design/adc_smoothing_glitch_check.sv @@
// Top level of the ADC smoothing and glitch check block: input register, state and result register.
// A beat passes the input register, then the result register; averages and scan state update as
// it leaves the input register. One beat per cycle is taken unless the result beat is stalled.
// Input stalls only while the input register is full and the result beat is stalled.
// Reset (rst_n low, asynchronous): averages and scan count clear, valid flags and settings reset.
module adc_smoothing_glitch_check
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  channel,
    input  logic [15:0] sample,
    input  logic        last_in_scan,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  chan_out,
    output logic [15:0] average,
    output logic        glitch,
    output logic        reinit_request,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    acs_pkg::cfg_t  cfg_reg;
    acs_pkg::item_t s1_item_reg;
    logic           s1_valid_reg;

    logic [15:0]    averages_reg [acs_pkg::CHANNELS];
    logic [8:0]     warm_count_reg;
    logic [8:0]     warm_count_next;
    logic           glitch_seen_reg;
    logic           glitch_seen_next;

    logic           out_valid_reg;
    logic [2:0]     chan_out_reg;
    logic [15:0]    average_reg;
    logic           glitch_reg;
    logic           reinit_reg;
    logic           reinit_next;

    logic           advance;
    logic           fire;
    logic           in_range;
    logic           warm;
    logic [acs_pkg::CH_IDX_W-1:0] ch_idx;
    logic [15:0]    stored_avg;
    acs_pkg::calc_t calc;

    assign cfg_ready = 1'b1;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = advance && s1_valid_reg;
    assign in_stall = s1_valid_reg && !advance;

    assign in_range   = 32'(s1_item_reg.channel) < 32'(acs_pkg::CHANNELS);
    assign ch_idx     = acs_pkg::CH_IDX_W'(s1_item_reg.channel);
    assign stored_avg = in_range ? averages_reg[ch_idx] : 16'd0;
    assign warm       = warm_count_reg <= acs_pkg::WARM_SCANS;

    acs_calc u_calc
    (
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .stored_avg (stored_avg),
        .in_range   (in_range),
        .warm       (warm),
        .res        (calc)
    );

    always_comb
    begin
        warm_count_next  = warm_count_reg;
        glitch_seen_next = glitch_seen_reg || calc.glitch;
        reinit_next      = 1'b0;
        if (s1_item_reg.last_in_scan)
        begin
            glitch_seen_next = 1'b0;
            if (warm)
            begin
                warm_count_next = warm_count_reg + 9'd1;
                reinit_next     = 1'b1;
            end
            else if (glitch_seen_reg || calc.glitch)
            begin
                warm_count_next = acs_pkg::WARM_REENTRY;
                reinit_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tolerance        <= acs_pkg::TOLERANCE_RESET;
            cfg_reg.active_channels  <= acs_pkg::ACTIVE_RESET;
            cfg_reg.checked_channels <= acs_pkg::CHECKED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                acs_pkg::CFG_TOLERANCE: cfg_reg.tolerance        <= cfg_data;
                acs_pkg::CFG_ACTIVE:    cfg_reg.active_channels  <= cfg_data[3:0];
                acs_pkg::CFG_CHECKED:   cfg_reg.checked_channels <= cfg_data[3:0];
                default:                ;
            endcase
        end
    end

    // Input register: load a beat whenever it is free to move on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_item_reg.channel      <= channel;
            s1_item_reg.sample       <= sample;
            s1_item_reg.last_in_scan <= last_in_scan;
        end
    end

    // Channel and scan state: advance as a beat passes into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < acs_pkg::CHANNELS; i++)
            begin
                averages_reg[i] <= 16'd0;
            end
            warm_count_reg  <= 9'd0;
            glitch_seen_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (calc.update)
            begin
                averages_reg[ch_idx] <= calc.average;
            end
            warm_count_reg  <= warm_count_next;
            glitch_seen_reg <= glitch_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            chan_out_reg <= s1_item_reg.channel;
            average_reg  <= calc.average;
            glitch_reg   <= calc.glitch;
            reinit_reg   <= reinit_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign chan_out       = chan_out_reg;
    assign average        = average_reg;
    assign glitch         = glitch_reg;
    assign reinit_request = reinit_reg;

endmodule

@@ design/acs_calc.sv @@
// Per-beat smoothing update and glitch window test for one sample.
module acs_calc
(
    input  acs_pkg::item_t  item,
    input  acs_pkg::cfg_t   cfg,
    input  logic [15:0]     stored_avg,
    input  logic            in_range,
    input  logic            warm,
    output acs_pkg::calc_t  res
);

    logic        active;
    logic        checked;
    logic [16:0] hi_bound;
    logic [15:0] lo_bound;
    logic        outside;
    logic [15:0] avg_third;
    logic [15:0] sample_third;
    logic [15:0] smoothed;

    assign active  = in_range && ({1'b0, item.channel} < cfg.active_channels);
    assign checked = active && !warm && ({1'b0, item.channel} < cfg.checked_channels);

    assign hi_bound = {1'b0, stored_avg} + {1'b0, cfg.tolerance};
    assign lo_bound = (stored_avg > cfg.tolerance) ? (stored_avg - cfg.tolerance) : 16'd0;
    assign outside  = ({1'b0, item.sample} > hi_bound) || (item.sample < lo_bound);

    assign avg_third    = acs_pkg::div3(stored_avg);
    assign sample_third = acs_pkg::div3(item.sample);
    assign smoothed     = {avg_third[14:0], 1'b0} + sample_third;

    always_comb
    begin
        res.update  = active;
        res.glitch  = checked && outside;
        res.average = active ? smoothed : stored_avg;
    end

endmodule

@@ design/acs_checker.sv @@
// Port-level assertions for the ADC smoothing and glitch check block, bound to the top level.
module acs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  channel,
    input logic [15:0] sample,
    input logic        last_in_scan,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  chan_out,
    input logic [15:0] average,
    input logic        glitch,
    input logic        reinit_request,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [15:0] cfg_data
);

    // Hold a stalled result beat unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(chan_out) && $stable(average)
            && $stable(glitch) && $stable(reinit_request))
        else $error("stalled result beat changed");

    // Stall input only when the result side is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    // A fresh result follows an input beat that was taken into the input register.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result beat without a preceding input beat");

    // Drop results while in reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("activity during reset");

endmodule

bind adc_smoothing_glitch_check acs_checker u_acs_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the ADC smoothing and glitch check block: table of beats, then scans.
module tb_top;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  chan;
        logic [15:0] avg;
        logic        glitch;
        logic        reinit;
    } smooth_beat_t;

    typedef struct packed {
        logic [2:0]  chan;
        logic [15:0] smp;
        logic        last;
        logic        known;
        logic [15:0] avg;
        logic        glitch;
        logic        reinit;
    } scan_row_t;

    // known rows start from cleared averages: average is sample / 3, warm-up asks for reinit
    localparam scan_row_t SCAN_TABLE [20] = '{
        '{3'd0, 16'd65535, 1'b0, 1'b1, 16'd21845, 1'b0, 1'b0},
        '{3'd7, 16'd0,     1'b1, 1'b1, 16'd0,     1'b0, 1'b1},
        '{3'd1, 16'd1,     1'b0, 1'b1, 16'd0,     1'b0, 1'b0},
        '{3'd2, 16'd2,     1'b0, 1'b1, 16'd0,     1'b0, 1'b0},
        '{3'd3, 16'd3,     1'b0, 1'b1, 16'd1,     1'b0, 1'b0},
        '{3'd4, 16'd32768, 1'b0, 1'b1, 16'd10922, 1'b0, 1'b0},
        '{3'd5, 16'd43690, 1'b0, 1'b1, 16'd14563, 1'b0, 1'b0},
        '{3'd6, 16'd21845, 1'b1, 1'b1, 16'd7281,  1'b0, 1'b1},
        '{3'd0, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
        '{3'd0, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
        '{3'd0, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
        '{3'd0, 16'd0,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
        '{3'd1, 16'd65535, 1'b1, 1'b0, 16'd0,     1'b0, 1'b0},
        '{3'd2, 16'd0,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
        '{3'd3, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
        '{3'd4, 16'd1,     1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
        '{3'd5, 16'd65534, 1'b1, 1'b0, 16'd0,     1'b0, 1'b0},
        '{3'd6, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
        '{3'd7, 16'd65535, 1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
        '{3'd7, 16'd0,     1'b1, 1'b0, 16'd0,     1'b0, 1'b0}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  channel = 3'd0;
    logic [15:0] sample = 16'd0;
    logic        last_in_scan = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  chan_out;
    logic [15:0] average;
    logic        glitch;
    logic        reinit_request;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    acs_pkg::cfg_index_t cfg_index = acs_pkg::CFG_TOLERANCE;
    logic [15:0] cfg_data = 16'd0;

    logic [15:0] chan_avg [acs_pkg::CHANNELS];
    logic [8:0]  scan_count;
    logic        scan_glitch;
    logic [15:0] tol_reg;
    logic [3:0]  active_reg;
    logic [3:0]  checked_reg;

    smooth_beat_t pending_results [$];
    smooth_beat_t oldest;

    int send_idle_pct = 32;
    int recv_idle_pct = 58;
    int mismatch_count = 0;
    int beat_count = 0;
    int result_count = 0;
    int glitch_total = 0;
    int reinit_total = 0;
    int setting_count = 1;
    int cycle_count = 0;
    int scan_pos = 0;

    adc_smoothing_glitch_check dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .channel        (channel),
        .sample         (sample),
        .last_in_scan   (last_in_scan),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chan_out       (chan_out),
        .average        (average),
        .glitch         (glitch),
        .reinit_request (reinit_request),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned clamp_to_channels(input logic [3:0] count);
        return (count > acs_pkg::CHANNELS) ? acs_pkg::CHANNELS : count;
    endfunction

    function automatic smooth_beat_t smooth_and_check(input logic [2:0] chan,
                                                      input logic [15:0] smp,
                                                      input logic last);
        smooth_beat_t res;
        int unsigned  avg;
        int unsigned  upper;
        int unsigned  lower;
        logic         warm;
        warm = (scan_count <= acs_pkg::WARM_SCANS);
        res = '0;
        res.chan = chan;
        avg = chan_avg[chan];
        if (chan < clamp_to_channels(active_reg))
        begin
            if (!warm && chan < clamp_to_channels(checked_reg))
            begin
                upper = avg + tol_reg;
                lower = (avg > tol_reg) ? avg - tol_reg : 0;
                if (smp > upper || smp < lower)
                begin
                    res.glitch = 1'b1;
                    scan_glitch = 1'b1;
                    glitch_total++;
                end
            end
            avg = avg / acs_pkg::SMOOTH_DIV * 2 + smp / acs_pkg::SMOOTH_DIV;
            chan_avg[chan] = 16'(avg);
        end
        res.avg = 16'(avg);
        if (last)
        begin
            if (warm)
            begin
                scan_count = scan_count + 9'd1;
                res.reinit = 1'b1;
            end
            else if (scan_glitch)
            begin
                scan_count = acs_pkg::WARM_REENTRY;
                res.reinit = 1'b1;
            end
            scan_glitch = 1'b0;
        end
        if (res.reinit)
            reinit_total++;
        return res;
    endfunction

    task automatic send_beat(input logic [2:0] chan, input logic [15:0] smp, input logic last,
                             input logic known, input smooth_beat_t typed);
        smooth_beat_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        channel <= chan;
        sample <= smp;
        last_in_scan <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beat_count++;
        predicted = smooth_and_check(chan, smp, last);
        pending_results.push_back(known ? typed : predicted);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input acs_pkg::cfg_index_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            acs_pkg::CFG_TOLERANCE: tol_reg = data;
            acs_pkg::CFG_ACTIVE:    active_reg = data[3:0];
            acs_pkg::CFG_CHECKED:   checked_reg = data[3:0];
            default:                ;
        endcase
    endtask

    task automatic run_phase(input logic [15:0] tol, input logic [3:0] act,
                             input logic [3:0] chk, input int beats);
        int          n;
        int          span;
        int          pick;
        int          near;
        logic [2:0]  chan;
        logic [15:0] smp;
        logic        last;
        drain_pipeline();
        write_reg(acs_pkg::CFG_TOLERANCE, tol);
        write_reg(acs_pkg::CFG_ACTIVE, {12'($urandom), act});
        write_reg(acs_pkg::CFG_CHECKED, {12'($urandom), chk});
        cfg_valid <= 1'b0;
        setting_count++;
        scan_pos = 0;
        n = clamp_to_channels(active_reg);
        span = 2 * int'(tol_reg) + 4;
        repeat (beats)
        begin
            if (n == 0 || $urandom_range(99) < 12)
            begin
                chan = 3'($urandom);
                last = ($urandom_range(2) == 0);
            end
            else
            begin
                chan = 3'(scan_pos);
                last = (scan_pos == n - 1);
                scan_pos = last ? 0 : scan_pos + 1;
            end
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                near = int'(chan_avg[chan]) + int'($urandom_range(2 * span)) - span;
                smp = (near < 0) ? 16'd0 : (near > 65535) ? 16'hFFFF : 16'(near);
            end
            else if (pick < 90)
                smp = 16'($urandom);
            else if (pick < 95)
                smp = 16'd0;
            else
                smp = 16'hFFFF;
            send_beat(chan, smp, last, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result beat %0d with nothing expected: chan %0d average %0d",
                             result_count, chan_out, average);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (chan_out !== oldest.chan || average !== oldest.avg
                    || glitch !== oldest.glitch || reinit_request !== oldest.reinit)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result beat %0d: expected chan %0d avg %0d glitch %0b",
                                 result_count, oldest.chan, oldest.avg, oldest.glitch,
                                 " reinit %0b, got chan %0d avg %0d glitch %0b reinit %0b",
                                 oldest.reinit, chan_out, average, glitch, reinit_request);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("adc_smoothing_glitch_check regression: fail");
            $finish;
        end
    end

    initial
    begin
        tol_reg = acs_pkg::TOLERANCE_RESET;
        active_reg = acs_pkg::ACTIVE_RESET;
        checked_reg = acs_pkg::CHECKED_RESET;
        foreach (chan_avg[i])
            chan_avg[i] = 16'd0;
        scan_count = 9'd0;
        scan_glitch = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCAN_TABLE[i])
            send_beat(SCAN_TABLE[i].chan, SCAN_TABLE[i].smp, SCAN_TABLE[i].last,
                      SCAN_TABLE[i].known,
                      '{SCAN_TABLE[i].chan, SCAN_TABLE[i].avg, SCAN_TABLE[i].glitch,
                        SCAN_TABLE[i].reinit});

        run_phase(16'd1000, 4'd1, 4'd1, 340);
        run_phase(16'd0, 4'd8, 4'd8, 300);

        send_idle_pct = 58;
        recv_idle_pct = 32;
        run_phase(16'hFFFF, 4'd15, 4'd15, 250);
        run_phase(16'd200, 4'd4, 4'd2, 300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(16'd50, 4'd0, 4'd0, 100);
        run_phase(16'd3000, 4'd6, 4'd8, 300);
        repeat (3)
            run_phase(16'($urandom_range(5000)), 4'($urandom_range(1, 8)),
                      4'($urandom_range(0, 9)), 100);

        drain_pipeline();
        repeat (8) @(posedge clk);

        $display("%0d input beats and %0d result beats over %0d register settings",
                 beat_count, result_count, setting_count);
        $display("%0d glitches and %0d re-initialisation requests predicted, %0d mismatches",
                 glitch_total, reinit_total, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("adc_smoothing_glitch_check regression: pass");
        else
            $display("adc_smoothing_glitch_check regression: fail");
        $finish;
    end

endmodule

@@ adc_smoothing_glitch_check.f @@
design/acs_pkg.sv
design/acs_calc.sv
design/adc_smoothing_glitch_check.sv
design/acs_checker.sv
verif/tb_top.sv
